// ===== src/pna_pkg.sv =====
// Shared constants and types for the page next-use annotator.
`default_nettype none

package pna_pkg;

    localparam int ADDR_W    = 48;
    localparam int INSTR_W   = 40;
    localparam int CNT_W     = 13;
    localparam int SHIFT_W   = 6;
    localparam int SLOTS     = 5;
    localparam int SLOT_W    = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int DEF_TABLE_ENTRIES = 4096;
    localparam int DEF_MAX_PAGES     = 5;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 6'd12;

    // Register index decoded from paddr[PADDR_W-1:2].
    localparam logic REG_PAGE_SHIFT = 1'b0;

    typedef enum logic [1:0] {
        EST_EMPTY   = 2'd0,
        EST_VALID   = 2'd1,
        EST_DELETED = 2'd2
    } t_entry_state;

    typedef struct packed {
        t_entry_state       st;
        logic [ADDR_W-1:0]  key;
        logic [INSTR_W-1:0] nu;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// ===== src/pna_ifs.sv =====
// Valid/ready channel interfaces for input items and result words.
`default_nettype none

interface pna_in_if;
    logic                        valid;
    logic                        ready;
    logic [pna_pkg::INSTR_W-1:0] instr_index;
    logic [2:0]                  page_count;
    logic [pna_pkg::ADDR_W-1:0]  access_addr0;
    logic [pna_pkg::ADDR_W-1:0]  access_addr1;
    logic [pna_pkg::ADDR_W-1:0]  access_addr2;
    logic [pna_pkg::ADDR_W-1:0]  access_addr3;
    logic [pna_pkg::ADDR_W-1:0]  access_addr4;
    logic                        output_first_use;
    logic [pna_pkg::ADDR_W-1:0]  output_addr;

    modport source (
        output valid, instr_index, page_count, access_addr0, access_addr1, access_addr2,
               access_addr3, access_addr4, output_first_use, output_addr,
        input  ready
    );
    modport sink (
        input  valid, instr_index, page_count, access_addr0, access_addr1, access_addr2,
               access_addr3, access_addr4, output_first_use, output_addr,
        output ready
    );
endinterface

interface pna_out_if;
    logic                        valid;
    logic                        ready;
    logic [pna_pkg::INSTR_W-1:0] nxt_idx0;
    logic [pna_pkg::INSTR_W-1:0] nxt_idx1;
    logic [pna_pkg::INSTR_W-1:0] nxt_idx2;
    logic [pna_pkg::INSTR_W-1:0] nxt_idx3;
    logic [pna_pkg::INSTR_W-1:0] nxt_idx4;
    logic [4:0]                  nxt_known;
    logic [pna_pkg::CNT_W-1:0]   working_set;
    logic [pna_pkg::CNT_W-1:0]   max_working_set;
    logic                        table_overflow;

    modport source (
        output valid, nxt_idx0, nxt_idx1, nxt_idx2, nxt_idx3, nxt_idx4,
               nxt_known, working_set, max_working_set, table_overflow,
        input  ready
    );
    modport sink (
        input  valid, nxt_idx0, nxt_idx1, nxt_idx2, nxt_idx3, nxt_idx4,
               nxt_known, working_set, max_working_set, table_overflow,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/pna_table_ram.sv =====
// Page table memory: one write port, one read port with registered data.
`default_nettype none

module pna_table_ram #(
    parameter int DEPTH = pna_pkg::DEF_TABLE_ENTRIES,
    parameter int WIDTH = pna_pkg::ENTRY_W
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/pna_page_unit.sv =====
// Shared page unit: address to page number shift and home-bucket hash.
`default_nettype none

module pna_page_unit #(
    parameter int TABLE_ENTRIES = pna_pkg::DEF_TABLE_ENTRIES
) (
    input  wire [pna_pkg::ADDR_W-1:0]        i_addr,
    input  wire [pna_pkg::SHIFT_W-1:0]       i_shift,
    output logic [pna_pkg::ADDR_W-1:0]       o_page,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_hash
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic [IW-1:0] fold;
    logic [IW:0]   fold_ext;

    always_comb begin
        // shift of 48 or more clears the page
        o_page = i_addr >> i_shift;
        fold   = '0;
        for (int i = 0; i < pna_pkg::ADDR_W; i++) begin
            fold[i % IW] = fold[i % IW] ^ o_page[i];
        end
        fold_ext = {1'b0, fold};
        // fold is below twice the depth: one conditional subtract
        if (fold_ext >= (IW+1)'(TABLE_ENTRIES)) begin
            o_hash = IW'(fold_ext - (IW+1)'(TABLE_ENTRIES));
        end else begin
            o_hash = fold;
        end
    end

endmodule

`default_nettype wire

// ===== src/page_next_use_annotator.sv =====
// Top level: page next-use annotator with hashed page table and probe sequencer.
// Each lookup passes through S_SHIFT, then S_READ and S_CHECK once per probe; a word's
//   result is registered in S_REPORT, which waits while the output register is held.
// A new word is taken only in S_IDLE, after all its slot lookups and, when
//   output_first_use is set, a removal lookup for output_addr have finished.
// Reset: synchronous, active low; afterwards a clearing pass in S_CLEAR marks every
//   entry empty before the first input word is taken.
`default_nettype none

module page_next_use_annotator #(
    parameter int TABLE_ENTRIES = pna_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_PAGES     = pna_pkg::DEF_MAX_PAGES
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [pna_pkg::PADDR_W-1:0]   paddr,
    input  wire [pna_pkg::PDATA_W-1:0]   pwdata,
    output logic [pna_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    // channels
    pna_in_if.sink                       i_item,
    pna_out_if.source                    o_res
);

    localparam int TIDX_W = $clog2(TABLE_ENTRIES);
    localparam int LIVE_W = $clog2(TABLE_ENTRIES + 1);
    localparam int LIMIT  = (MAX_PAGES < pna_pkg::SLOTS) ? MAX_PAGES : pna_pkg::SLOTS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SHIFT,
        S_READ,
        S_CHECK,
        S_REPORT
    } t_state;

    t_state                          r_state;
    logic [TIDX_W-1:0]               r_clr_idx;
    logic [pna_pkg::SHIFT_W-1:0]     r_shift;

    // latched input word
    logic [pna_pkg::INSTR_W-1:0]     r_inum;
    logic [pna_pkg::SLOT_W-1:0]      r_count;
    logic [pna_pkg::ADDR_W-1:0]      r_addr [pna_pkg::SLOTS];
    logic                            r_first;
    logic [pna_pkg::ADDR_W-1:0]      r_oaddr;

    // lookup in flight
    logic [pna_pkg::SLOT_W-1:0]      r_slot;
    logic                            r_remove;
    logic [pna_pkg::ADDR_W-1:0]      r_page;
    logic [TIDX_W-1:0]               r_probe;
    logic [TIDX_W-1:0]               r_steps;
    logic                            r_ins_found;
    logic [TIDX_W-1:0]               r_ins_idx;

    // per-word results and running counts
    logic [pna_pkg::INSTR_W-1:0]     r_nu [pna_pkg::SLOTS];
    logic [pna_pkg::SLOTS-1:0]       r_known;
    logic [LIVE_W-1:0]               r_live;
    logic [LIVE_W-1:0]               r_peak;
    logic                            r_ovf;

    // output register
    logic                            r_out_valid;
    logic [pna_pkg::INSTR_W-1:0]     r_out_nu [pna_pkg::SLOTS];
    logic [pna_pkg::SLOTS-1:0]       r_out_known;
    logic [pna_pkg::CNT_W-1:0]       r_out_ws;
    logic [pna_pkg::CNT_W-1:0]       r_out_max;
    logic                            r_out_ovf;

    // page unit
    logic [pna_pkg::ADDR_W-1:0]      pu_addr;
    logic [pna_pkg::ADDR_W-1:0]      pu_page;
    logic [TIDX_W-1:0]               pu_hash;

    // memory
    logic                            ram_we;
    logic [TIDX_W-1:0]               ram_waddr;
    pna_pkg::t_entry                 ram_wentry;
    logic [pna_pkg::ENTRY_W-1:0]     ram_rdata;
    pna_pkg::t_entry                 ent;

    logic                            chk_hit;
    logic                            chk_empty;
    logic                            chk_last;
    logic                            chk_free;
    logic                            ins_ok;
    logic [TIDX_W-1:0]               ins_idx;
    logic [TIDX_W-1:0]               n_probe;
    logic [LIVE_W-1:0]               n_peak;
    logic                            cfg_wr;
    logic [pna_pkg::SLOT_W-1:0]      sat_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[pna_pkg::PADDR_W-1:2] == pna_pkg::REG_PAGE_SHIFT) begin
            prdata = pna_pkg::PDATA_W'(r_shift);
        end else begin
            prdata = '0;
        end
    end

    // slot count saturates at the smaller of MAX_PAGES and five
    always_comb begin
        if (i_item.page_count > pna_pkg::SLOT_W'(LIMIT)) begin
            sat_count = pna_pkg::SLOT_W'(LIMIT);
        end else begin
            sat_count = i_item.page_count;
        end
    end

    assign pu_addr = r_remove ? r_oaddr
                   : ((r_slot < pna_pkg::SLOT_W'(pna_pkg::SLOTS)) ? r_addr[r_slot] : '0);

    pna_page_unit #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_page (
        .i_addr  (pu_addr),
        .i_shift (r_shift),
        .o_page  (pu_page),
        .o_hash  (pu_hash)
    );

    pna_table_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (pna_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_raddr (r_probe),
        .o_rdata (ram_rdata)
    );

    // probe evaluation: linear probing with tombstones
    always_comb begin
        ent       = pna_pkg::t_entry'(ram_rdata);
        chk_hit   = (ent.st == pna_pkg::EST_VALID) && (ent.key == r_page);
        chk_empty = (ent.st == pna_pkg::EST_EMPTY);
        chk_free  = (ent.st != pna_pkg::EST_VALID);
        chk_last  = (r_steps == TIDX_W'(TABLE_ENTRIES - 1));
        ins_ok    = r_ins_found || chk_free;
        ins_idx   = r_ins_found ? r_ins_idx : r_probe;
        n_probe   = (r_probe == TIDX_W'(TABLE_ENTRIES - 1)) ? '0 : r_probe + 1'b1;
        n_peak    = (r_live > r_peak) ? r_live : r_peak;

        ram_we     = 1'b0;
        ram_waddr  = r_probe;
        ram_wentry = ent;
        unique case (r_state)
            S_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = r_clr_idx;
                ram_wentry.st = pna_pkg::EST_EMPTY;
            end
            S_CHECK: begin
                if (chk_hit) begin
                    ram_we = 1'b1;
                    if (r_remove) begin
                        ram_wentry.st = pna_pkg::EST_DELETED;
                    end else begin
                        ram_wentry.nu = r_inum;
                    end
                end else if ((chk_empty || chk_last) && !r_remove && ins_ok) begin
                    ram_we         = 1'b1;
                    ram_waddr      = ins_idx;
                    ram_wentry.st  = pna_pkg::EST_VALID;
                    ram_wentry.key = r_page;
                    ram_wentry.nu  = r_inum;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_item.ready = (r_state == S_IDLE);

    assign o_res.valid           = r_out_valid;
    assign o_res.nxt_idx0        = r_out_nu[0];
    assign o_res.nxt_idx1        = r_out_nu[1];
    assign o_res.nxt_idx2        = r_out_nu[2];
    assign o_res.nxt_idx3        = r_out_nu[3];
    assign o_res.nxt_idx4        = r_out_nu[4];
    assign o_res.nxt_known       = r_out_known;
    assign o_res.working_set     = r_out_ws;
    assign o_res.max_working_set = r_out_max;
    assign o_res.table_overflow  = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_shift     <= pna_pkg::PAGE_SHIFT_RESET;
            r_live      <= '0;
            r_peak      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_remove    <= 1'b0;
        end else begin
            if (cfg_wr && paddr[pna_pkg::PADDR_W-1:2] == pna_pkg::REG_PAGE_SHIFT) begin
                r_shift <= pwdata[pna_pkg::SHIFT_W-1:0];
            end
            // S_REPORT reloads the output register itself
            if (r_out_valid && o_res.ready && r_state != S_REPORT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == TIDX_W'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_inum    <= i_item.instr_index;
                        r_count   <= sat_count;
                        r_addr[0] <= i_item.access_addr0;
                        r_addr[1] <= i_item.access_addr1;
                        r_addr[2] <= i_item.access_addr2;
                        r_addr[3] <= i_item.access_addr3;
                        r_addr[4] <= i_item.access_addr4;
                        r_first   <= i_item.output_first_use;
                        r_oaddr   <= i_item.output_addr;
                        r_slot    <= '0;
                        r_remove  <= 1'b0;
                        r_known   <= '0;
                        for (int i = 0; i < pna_pkg::SLOTS; i++) begin
                            r_nu[i] <= '0;
                        end
                        r_state   <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_remove || r_slot < r_count) begin
                        r_page      <= pu_page;
                        r_probe     <= pu_hash;
                        r_steps     <= '0;
                        r_ins_found <= 1'b0;
                        r_state     <= S_READ;
                    end else begin
                        r_state <= S_REPORT;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (chk_hit || chk_empty || chk_last) begin
                        if (chk_hit) begin
                            if (r_remove) begin
                                r_live <= r_live - 1'b1;
                            end else begin
                                r_nu[r_slot]    <= ent.nu;
                                r_known[r_slot] <= 1'b1;
                            end
                        end else if (!r_remove) begin
                            if (ins_ok) begin
                                r_live <= r_live + 1'b1;
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                        if (r_remove) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= r_slot + 1'b1;
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        // remember the first reusable entry on the chain
                        if (chk_free && !r_ins_found) begin
                            r_ins_found <= 1'b1;
                            r_ins_idx   <= r_probe;
                        end
                        r_probe <= n_probe;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_REPORT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_peak      <= n_peak;
                        r_out_valid <= 1'b1;
                        for (int i = 0; i < pna_pkg::SLOTS; i++) begin
                            r_out_nu[i] <= r_nu[i];
                        end
                        r_out_known <= r_known;
                        r_out_ws    <= pna_pkg::CNT_W'(r_live);
                        r_out_max   <= pna_pkg::CNT_W'(n_peak);
                        r_out_ovf   <= r_ovf;
                        if (r_first) begin
                            r_remove <= 1'b1;
                            r_state  <= S_SHIFT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
